// File: rtl/core/swm_pkg.sv
package swm_pkg;

  // Default sizing of the candidate chain and the sample datapath.
  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;

  // Window size register.
  localparam int              CFG_W        = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic step;   // a sample is accepted this cycle
    logic shift;  // the chain moves one place toward the front
    logic clear;  // a new sequence starts, all candidates are dropped
  } cell_ctrl_t;

endpackage

// File: rtl/core/swm_in_if.sv
interface swm_in_if #(
  parameter int SW = swm_pkg::SAMPLE_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample;
  logic                 start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

// File: rtl/core/swm_out_if.sv
interface swm_out_if #(
  parameter int SW = swm_pkg::SAMPLE_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] window_max;

  modport source (output valid, window_max, input ready);
  modport sink   (input valid, window_max, output ready);
endinterface

// File: rtl/core/sliding_window_maximum.sv
// A result stands in the output register in the cycle after its sample is accepted.
// Throughput: one sample per cycle while results are taken; a sample waits while the chain
// purges each stale front candidate beyond the first, which happens only after window_size shrinks.
// Reset clears all candidates and the sample count, empties the output register and sets
// window_size to 1.
module sliding_window_maximum #(
  parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata,
  swm_in_if.sink                     samples,
  swm_out_if.source                  results
);

  localparam int AW = $clog2(MAX_WINDOW + 1);
  localparam int KW = (AW > swm_pkg::CFG_W) ? AW : swm_pkg::CFG_W;

  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [AW-1:0]             samples_seen;
  logic [AW-1:0]             seen_next;
  logic [KW-1:0]             k_eff;
  logic                      exp0;
  logic                      exp1;
  logic                      purge;
  logic                      accept;
  logic                      drop;
  logic                      has_result;
  logic                      out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_value;
  swm_pkg::cell_ctrl_t       ctrl;

  logic                           cv_valid   [MAX_WINDOW+1];
  logic signed [SAMPLE_WIDTH-1:0] cv_value   [MAX_WINDOW+1];
  logic [AW-1:0]                  cv_age     [MAX_WINDOW+1];
  logic                           cv_survive [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cv_next    [MAX_WINDOW];

  // Window size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  // Effective window: zero counts as one, sizes past the chain length are clamped.
  always_comb begin
    if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (KW'(window_size) > KW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(window_size);
    end
  end

  // Front candidates that leave the window once aged by one more sample.
  assign exp0 = cv_valid[0] && ((KW + 1)'(cv_age[0]) + (KW + 1)'(1) >= (KW + 1)'(k_eff));
  assign exp1 = cv_valid[1] && ((KW + 1)'(cv_age[1]) + (KW + 1)'(1) >= (KW + 1)'(k_eff));

  // More than one stale front candidate: move the chain before taking the sample.
  assign purge  = samples.valid && !samples.start_req && exp0 && exp1;
  assign samples.ready = !purge && (!out_valid || results.ready);
  assign accept = samples.valid && samples.ready;
  assign drop   = exp0 && !samples.start_req;

  always_comb begin
    ctrl.step  = accept;
    ctrl.shift = accept ? drop : purge;
    ctrl.clear = accept && samples.start_req;
  end

  // Chain of candidate cells, front at place zero.
  assign cv_valid[MAX_WINDOW]   = 1'b0;
  assign cv_value[MAX_WINDOW]   = '0;
  assign cv_age[MAX_WINDOW]     = '0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic lt_survive;
    if (i == 0) begin : g_front
      assign lt_survive = 1'b1;
    end else begin : g_rest
      assign lt_survive = cv_survive[i-1];
    end

    swm_cell #(
      .SW   (SAMPLE_WIDTH),
      .MAXW (MAX_WINDOW),
      .AW   (AW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (samples.sample),
      .rt_valid   (cv_valid[i+1]),
      .rt_value   (cv_value[i+1]),
      .rt_age     (cv_age[i+1]),
      .lt_survive (lt_survive),
      .valid      (cv_valid[i]),
      .value      (cv_value[i]),
      .age        (cv_age[i]),
      .survive    (cv_survive[i]),
      .next_value (cv_next[i])
    );
  end

  // Sample count of the current sequence, saturating at the chain length.
  always_comb begin
    if (samples.start_req) begin
      seen_next = AW'(1);
    end else if (samples_seen >= AW'(MAX_WINDOW)) begin
      seen_next = samples_seen;
    end else begin
      seen_next = samples_seen + AW'(1);
    end
  end

  assign has_result = KW'(seen_next) >= k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept) begin
      samples_seen <= seen_next;
    end
  end

  // Output register: the new front candidate is the window maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= has_result;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_value <= cv_next[0];
    end
  end

  assign results.valid      = out_valid;
  assign results.window_max = out_value;

endmodule

// File: rtl/core/swm_cell.sv
module swm_cell #(
  parameter int SW   = swm_pkg::SAMPLE_WIDTH,
  parameter int MAXW = swm_pkg::MAX_WINDOW,
  parameter int AW   = $clog2(MAXW + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swm_pkg::cell_ctrl_t  ctrl,
  input  logic signed [SW-1:0] sample,
  // Stored entry of the neighbor one place further back.
  input  logic                 rt_valid,
  input  logic signed [SW-1:0] rt_value,
  input  logic [AW-1:0]        rt_age,
  // The neighbor one place further front keeps its candidate.
  input  logic                 lt_survive,
  output logic                 valid,
  output logic signed [SW-1:0] value,
  output logic [AW-1:0]        age,
  output logic                 survive,
  output logic signed [SW-1:0] next_value
);

  logic                 src_valid;
  logic signed [SW-1:0] src_value;
  logic [AW-1:0]        src_age;
  logic [AW-1:0]        age_inc;
  logic                 take_new;

  // Entry seen by this place after an optional front drop.
  always_comb begin
    src_valid = ctrl.shift ? rt_valid : valid;
    src_value = ctrl.shift ? rt_value : value;
    src_age   = ctrl.shift ? rt_age   : age;
    if (ctrl.clear) begin
      src_valid = 1'b0;
    end
  end

  // A candidate stays only while it is strictly larger than the new sample.
  assign survive    = src_valid && (src_value > sample);
  assign take_new   = !survive && lt_survive;
  assign next_value = survive ? src_value : sample;
  assign age_inc    = (src_age >= AW'(MAXW)) ? src_age : src_age + AW'(1);

  // Cell storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
    end else if (ctrl.step) begin
      valid <= survive || take_new;
      value <= next_value;
      age   <= survive ? age_inc : '0;
    end else if (ctrl.shift) begin
      valid <= rt_valid;
      value <= rt_value;
      age   <= rt_age;
    end
  end

endmodule

// File: bench/sliding_window_maximum_test.sv
module sliding_window_maximum_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW            = swm_pkg::SAMPLE_WIDTH;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1250;

  typedef enum logic {REQ_SAMPLE, REQ_WINDOW} req_kind_t;
  typedef enum int {PAT_RANDOM, PAT_CLUSTER, PAT_FALLING, PAT_RISING, PAT_EXTREME} pattern_t;

  typedef struct {
    req_kind_t                 kind;
    logic signed [SW-1:0]      sample;
    logic                      start;
    logic [swm_pkg::CFG_W-1:0] window;
    int                        gap;
  } request_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [swm_pkg::CFG_W-1:0] cfg_wdata;

  swm_in_if  #(.SW(SW)) sample_bus ();
  swm_out_if #(.SW(SW)) max_bus ();

  sliding_window_maximum #(
    .MAX_WINDOW  (swm_pkg::MAX_WINDOW),
    .SAMPLE_WIDTH(SW)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .samples  (sample_bus),
    .results  (max_bus)
  );

  // Requests waiting to be driven and window maxima waiting to come out.
  request_t             pending_q[$];
  logic signed [SW-1:0] expected_max_q[$];

  // Predictor state: candidates in decreasing order, front is the window maximum.
  logic signed [SW-1:0]      held_val[swm_pkg::MAX_WINDOW];
  int                        held_age[swm_pkg::MAX_WINDOW];
  int                        held_cnt;
  int                        seq_len;
  logic [swm_pkg::CFG_W-1:0] window_reg;

  int  error_count;
  int  samples_taken;
  int  maxima_checked;
  int  window_writes;
  bit  in_fired;
  bit  out_fired;
  bit  sender_steady;

  // Driver state.
  request_t cur_req;
  bit       req_loaded;
  int       settle_cnt;
  logic     valid_nxt;
  logic     we_nxt;

  // Receiver state.
  int  sink_hold;
  int  sink_mode_left;
  bit  sink_steady;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic push_sample(input logic signed [SW-1:0] value, input logic start);
    request_t req;
    req.kind   = REQ_SAMPLE;
    req.sample = value;
    req.start  = start;
    req.window = '0;
    req.gap    = sender_steady ? 0 : $urandom_range(0, 9);
    pending_q  = {pending_q, req};
  endtask

  task automatic push_window(input logic [swm_pkg::CFG_W-1:0] value);
    request_t req;
    req.kind   = REQ_WINDOW;
    req.sample = '0;
    req.start  = 1'b0;
    req.window = value;
    req.gap    = 0;
    pending_q  = {pending_q, req};
  endtask

  // Takes one sample into the candidate store and tells whether a maximum is due.
  function automatic void predict_window_max(input logic signed [SW-1:0] value,
                                             input logic start,
                                             output bit produced,
                                             output logic signed [SW-1:0] max_value);
    int k;
    int drop;
    if (window_reg == 0) k = 1;
    else if (window_reg > swm_pkg::MAX_WINDOW) k = swm_pkg::MAX_WINDOW;
    else k = window_reg;

    if (start) begin
      held_cnt = 0;
      seq_len  = 0;
    end

    // Every held candidate grows one step older.
    for (int i = 0; i < held_cnt; i++) begin
      if (held_age[i] < swm_pkg::MAX_WINDOW) held_age[i]++;
    end

    // Candidates that have left the window go from the front.
    drop = 0;
    while (drop < held_cnt && held_age[drop] >= k) drop++;
    for (int i = 0; i + drop < held_cnt; i++) begin
      held_val[i] = held_val[i + drop];
      held_age[i] = held_age[i + drop];
    end
    held_cnt -= drop;

    // Candidates not above the new sample can never win again.
    while (held_cnt > 0 && held_val[held_cnt - 1] <= value) held_cnt--;

    if (held_cnt < swm_pkg::MAX_WINDOW) begin
      held_val[held_cnt] = value;
      held_age[held_cnt] = 0;
      held_cnt++;
    end

    if (seq_len < swm_pkg::MAX_WINDOW) seq_len++;

    produced  = (seq_len >= k) && (held_cnt > 0);
    max_value = held_val[0];
  endfunction

  // Monitor: tracks register writes, predicts on every accepted sample and checks results.
  always @(posedge clk) begin
    bit                   produced;
    logic signed [SW-1:0] max_value;
    logic signed [SW-1:0] want;
    in_fired  = sample_bus.valid && sample_bus.ready;
    out_fired = max_bus.valid && max_bus.ready;
    if (rst) begin
      held_cnt   = 0;
      seq_len    = 0;
      window_reg = swm_pkg::WINDOW_RESET;
    end else begin
      if (cfg_we) begin
        window_reg = cfg_wdata;
        window_writes++;
      end
      if (in_fired) begin
        samples_taken++;
        predict_window_max(sample_bus.sample, sample_bus.start_req, produced, max_value);
        if (produced) expected_max_q = {expected_max_q, max_value};
      end
      if (out_fired) begin
        if (expected_max_q.size() == 0) begin
          report_mismatch($sformatf("unexpected window_max %0d", max_bus.window_max));
        end else begin
          want = expected_max_q.pop_front();
          maxima_checked++;
          if (max_bus.window_max !== want) begin
            report_mismatch($sformatf("window_max %0d, expected %0d",
                                      max_bus.window_max, want));
          end
        end
      end
    end
  end

  // Driver: presents samples with random gaps; window writes wait until the block drains.
  always @(negedge clk) begin
    valid_nxt = sample_bus.valid;
    we_nxt    = 1'b0;
    if (!rst) begin
      if (sample_bus.valid && in_fired) valid_nxt = 1'b0;
      if (!valid_nxt) begin
        if (!req_loaded && pending_q.size() != 0) begin
          cur_req    = pending_q.pop_front();
          req_loaded = 1'b1;
          settle_cnt = 0;
        end
        if (req_loaded) begin
          if (cur_req.kind == REQ_SAMPLE) begin
            if (cur_req.gap > 0) begin
              cur_req.gap--;
            end else begin
              sample_bus.sample    <= cur_req.sample;
              sample_bus.start_req <= cur_req.start;
              valid_nxt  = 1'b1;
              req_loaded = 1'b0;
            end
          end else if (expected_max_q.size() != 0) begin
            settle_cnt = 0;
          end else if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt++;
          end else begin
            cfg_wdata  <= cur_req.window;
            we_nxt     = 1'b1;
            req_loaded = 1'b0;
          end
        end
      end
    end
    sample_bus.valid <= valid_nxt;
    cfg_we           <= we_nxt;
  end

  // Receiver: stalls a random number of cycles after each result, with steady stretches.
  always @(negedge clk) begin
    if (out_fired) begin
      sink_hold = sink_steady ? 0 : $urandom_range(0, 9);
    end else if (sink_hold > 0) begin
      sink_hold--;
    end
    sink_mode_left--;
    if (sink_mode_left <= 0) begin
      sink_steady    = ($urandom_range(0, 3) == 0);
      sink_mode_left = $urandom_range(50, 300);
    end
    max_bus.ready <= !rst && (sink_hold == 0);
  end

  // Watchdog for a hung run.
  initial begin
    #(3_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [swm_pkg::CFG_W-1:0] win;
    logic signed [SW-1:0]      level;
    pattern_t                  pattern;
    int                        k_eff;
    int                        plen;
    int                        random_count;
    int                        guard;
    bit                        fresh;
    bit                        first;

    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    sample_bus.valid     = 1'b0;
    sample_bus.sample    = '0;
    sample_bus.start_req = 1'b0;
    max_bus.ready        = 1'b0;
    sink_hold            = 0;
    sink_mode_left       = 0;
    req_loaded           = 1'b0;
    sender_steady        = 1'b0;

    // Directed: extremes under the reset window of one sample.
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh0000_0000, 1'b0);
    push_sample(-32'sd1, 1'b1);

    // Directed: window of four with equal samples and both extremes.
    push_window(7'd4);
    push_sample(32'sd5, 1'b1);
    push_sample(32'sd5, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sd3, 1'b0);
    push_sample(32'sd5, 1'b0);
    push_sample(32'sh7FFF_FFFF, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(-32'sd1, 1'b0);

    // Directed: a zero window behaves as one sample.
    push_window(7'd0);
    push_sample(32'sd9, 1'b1);
    push_sample(-32'sd9, 1'b0);

    // Directed: an oversized window clamps, then shrinks mid-sequence.
    push_window(7'd127);
    push_sample(32'sd40, 1'b1);
    push_sample(32'sd30, 1'b0);
    push_sample(32'sd20, 1'b0);
    push_window(7'd2);
    push_sample(32'sd10, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(-32'sd10, 1'b0);

    // Random phases: mostly whole sequences under one window size.
    win          = 7'd2;
    random_count = 0;
    first        = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0:       win = 7'd0;
          1:       win = ($urandom_range(0, 1) == 0) ? 7'd127 : 7'($urandom_range(65, 127));
          2:       win = 7'd64;
          3:       win = 7'd1;
          4, 5:    win = 7'($urandom_range(17, 63));
          default: win = 7'($urandom_range(1, 16));
        endcase
        push_window(win);
        first = 1'b0;
      end
      if (win == 0) k_eff = 1;
      else if (win > swm_pkg::MAX_WINDOW) k_eff = swm_pkg::MAX_WINDOW;
      else k_eff = win;
      fresh   = ($urandom_range(0, 3) != 0);
      plen    = (fresh ? k_eff : 0) + $urandom_range(4, 40);
      pattern = pattern_t'($urandom_range(0, 4));
      level   = $urandom;
      for (int i = 0; i < plen; i++) begin
        case (pattern)
          PAT_RANDOM:  level = $urandom;
          PAT_CLUSTER: level = $signed($urandom_range(0, 16)) - 8;
          PAT_FALLING: level = level - $signed($urandom_range(0, 1000));
          PAT_RISING:  level = level + $signed($urandom_range(0, 1000));
          default: begin
            case ($urandom_range(0, 4))
              0:       level = 32'sh7FFF_FFFF;
              1:       level = 32'sh8000_0000;
              2:       level = '0;
              3:       level = -32'sd1;
              default: level = $urandom;
            endcase
          end
        endcase
        push_sample(level, (i == 0 && fresh) || ($urandom_range(0, 59) == 0));
      end
      random_count += plen;
    end

    // Release reset.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all requests to go out, then for the last maxima.
    while (pending_q.size() != 0 || req_loaded || sample_bus.valid) @(posedge clk);
    guard = 0;
    while (expected_max_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES + 4) @(posedge clk);
    while (expected_max_q.size() != 0) begin
      report_mismatch($sformatf("window_max %0d never came out", expected_max_q.pop_front()));
    end

    $display("Drove %0d samples through %0d window size writes; checked %0d window maxima.",
             samples_taken, window_writes, maxima_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/swm_pkg.sv
rtl/core/swm_in_if.sv
rtl/core/swm_out_if.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_maximum.sv
bench/sliding_window_maximum_test.sv
